>>> hw/rtl/dso_pkg.sv
package dso_pkg;

    // fixed widths of the payload and the state
    localparam int POSITION_WIDTH = 48;
    localparam int HEADING_WIDTH  = 25;
    localparam int SCALE_WIDTH    = 24;
    localparam int STEP_WIDTH     = 16;

    // angle constants, Q9.16 degrees
    localparam logic [HEADING_WIDTH-1:0] FULL_TURN    = 25'd23592960;
    localparam logic [HEADING_WIDTH-1:0] QUARTER_TURN = 25'd5898240;

    // cordic gain 0.60725293 in Q3.30
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam int ATAN_DEPTH = 24;

    // turn delta reduction: shift-subtract steps
    localparam int MOD_STEPS = 8;

    // configuration register indexes
    localparam logic REG_RIGHT_SCALE = 1'b0;
    localparam logic REG_LEFT_SCALE  = 1'b1;

    // reset values of the scale registers
    localparam logic [SCALE_WIDTH-1:0] RIGHT_SCALE_RESET = 24'd1243780;
    localparam logic [SCALE_WIDTH-1:0] LEFT_SCALE_RESET  = 24'd1213786;

    // movement kinds
    localparam logic [1:0] CMD_NONE     = 2'd0;
    localparam logic [1:0] CMD_STRAIGHT = 2'd1;
    localparam logic [1:0] CMD_TURN     = 2'd2;

    // atan(2^-i) in Q.24 degrees
    localparam logic [31:0] ATAN_DEG [ATAN_DEPTH] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

    typedef struct packed {
        logic [1:0]                   cmd;
        logic signed [STEP_WIDTH-1:0] lstep_cnt;
        logic signed [STEP_WIDTH-1:0] rstep_cnt;
    } in_beat_t;

    typedef struct packed {
        logic signed [POSITION_WIDTH-1:0] pos_x;
        logic signed [POSITION_WIDTH-1:0] pos_y;
        logic [HEADING_WIDTH-1:0]         heading;
    } out_beat_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic cordic_step;
        logic mul_x;
        logic mul_y;
        logic add_y;
        logic turn_mul;
        logic turn_rnd;
        logic mod_step;
        logic turn_add;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_straight;
        logic is_turn;
        logic cordic_last;
        logic mod_last;
    } dp_stat_t;

endpackage

>>> hw/rtl/dso_ctrl.sv
module dso_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  dso_pkg::dp_stat_t stat,
    output dso_pkg::dp_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_CORDIC   = 10'b00_0000_0010,
        S_MUL_X    = 10'b00_0000_0100,
        S_MUL_Y    = 10'b00_0000_1000,
        S_ADD_Y    = 10'b00_0001_0000,
        S_TURN_MUL = 10'b00_0010_0000,
        S_TURN_RND = 10'b00_0100_0000,
        S_TURN_MOD = 10'b00_1000_0000,
        S_TURN_ADD = 10'b01_0000_0000,
        S_FINISH   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (stat.is_straight) begin
                        state_next = S_CORDIC;
                    end else if (stat.is_turn) begin
                        state_next = S_TURN_MUL;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_CORDIC: begin
                cmd.cordic_step = 1'b1;
                if (stat.cordic_last) begin
                    state_next = S_MUL_X;
                end
            end
            S_MUL_X: begin
                cmd.mul_x  = 1'b1;
                state_next = S_MUL_Y;
            end
            S_MUL_Y: begin
                cmd.mul_y  = 1'b1;
                state_next = S_ADD_Y;
            end
            S_ADD_Y: begin
                cmd.add_y  = 1'b1;
                state_next = S_FINISH;
            end
            S_TURN_MUL: begin
                cmd.turn_mul = 1'b1;
                state_next   = S_TURN_RND;
            end
            S_TURN_RND: begin
                cmd.turn_rnd = 1'b1;
                state_next   = S_TURN_MOD;
            end
            S_TURN_MOD: begin
                cmd.mod_step = 1'b1;
                if (stat.mod_last) begin
                    state_next = S_TURN_ADD;
                end
            end
            S_TURN_ADD: begin
                cmd.turn_add = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result beat valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> hw/rtl/dso_dp.sv
module dso_dp #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  dso_pkg::in_beat_t                    s_data,
    output dso_pkg::out_beat_t                   m_data,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [dso_pkg::SCALE_WIDTH-1:0]      cfg_wdata,
    input  dso_pkg::dp_cmd_t                     cmd,
    output dso_pkg::dp_stat_t                    stat
);

    localparam int IW  = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
    localparam int PW  = dso_pkg::POSITION_WIDTH;
    localparam int HW  = dso_pkg::HEADING_WIDTH;
    localparam int DW  = 38;
    localparam int SW  = ((PW > DW) ? PW : DW) + 1;
    localparam int MW  = 52;
    localparam int STEPW = dso_pkg::STEP_WIDTH;
    localparam logic signed [SW-1:0] PMAX = SW'((64'd1 << (PW - 1)) - 64'd1);
    localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);

    logic [dso_pkg::SCALE_WIDTH-1:0] rscale_reg, lscale_reg;
    logic signed [PW-1:0]  xpos_reg, ypos_reg;
    logic [HW-1:0]         head_reg;
    logic signed [STEPW-1:0] left_reg;
    logic [STEPW-1:0]      mag_reg;
    logic                  dneg_reg;
    logic signed [33:0]    cx_reg, cy_reg, cz_reg;
    logic                  flip_reg;
    logic [IW-1:0]         iter_reg;
    logic signed [MW-1:0]  prod_reg;
    logic [31:0]           rem_reg;
    logic [2:0]            k_reg;
    dso_pkg::out_beat_t    out_reg;

    // status to the controller
    assign stat.is_straight = (s_data.cmd == dso_pkg::CMD_STRAIGHT);
    assign stat.is_turn     = (s_data.cmd == dso_pkg::CMD_TURN);
    assign stat.cordic_last = (iter_reg == IW'(CORDIC_ITERATIONS - 1));
    assign stat.mod_last    = (k_reg == 3'd0);
    assign m_data           = out_reg;

    // step difference and its magnitude
    logic signed [STEPW:0] diff;
    logic [STEPW:0]        diff_abs;
    assign diff     = (STEPW+1)'(s_data.rstep_cnt) - (STEPW+1)'(s_data.lstep_cnt);
    assign diff_abs = diff[STEPW] ? (STEPW+1)'(-diff) : (STEPW+1)'(diff);

    // quadrant reduction of the heading into [-90, 90)
    logic signed [25:0] zred;
    logic               zflip;
    always_comb begin
        zflip = 1'b0;
        if (head_reg < dso_pkg::QUARTER_TURN) begin
            zred = 26'(head_reg);
        end else if ({1'b0, head_reg} < 26'(3) * {1'b0, dso_pkg::QUARTER_TURN}) begin
            zred  = 26'(head_reg) - 26'({dso_pkg::QUARTER_TURN, 1'b0});
            zflip = 1'b1;
        end else begin
            zred = 26'(head_reg) - 26'(dso_pkg::FULL_TURN);
        end
    end

    // one cordic rotation
    logic signed [33:0] xsh, ysh, atan_v;
    assign xsh    = cx_reg >>> iter_reg;
    assign ysh    = cy_reg >>> iter_reg;
    assign atan_v = 34'(dso_pkg::ATAN_DEG[5'(iter_reg)]);

    // shared multiplier operands
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [MW-1:0] mul_p;
    always_comb begin
        if (cmd.turn_mul) begin
            mul_a = 34'({10'd0, dso_pkg::SCALE_WIDTH'(dneg_reg ? lscale_reg : rscale_reg)});
            mul_b = 18'({2'b00, mag_reg});
        end else if (cmd.mul_x) begin
            mul_a = flip_reg ? -cx_reg : cx_reg;
            mul_b = 18'(left_reg);
        end else begin
            mul_a = flip_reg ? -cy_reg : cy_reg;
            mul_b = 18'(left_reg);
        end
        mul_p = MW'(mul_a) * MW'(mul_b);
    end

    // rounded position delta and saturating add
    logic signed [MW-1:0] prnd;
    logic signed [SW-1:0] pdelta, psum, pbase;
    logic signed [PW-1:0] psat;
    assign prnd   = (prod_reg + MW'(8192)) >>> 14;
    assign pdelta = SW'(prnd);
    assign pbase  = cmd.mul_y ? SW'(xpos_reg) : SW'(ypos_reg);
    assign psum   = pbase + pdelta;
    always_comb begin
        if (psum > PMAX) begin
            psat = PW'(PMAX);
        end else if (psum < PMIN) begin
            psat = PW'(PMIN);
        end else begin
            psat = PW'(psum);
        end
    end

    // modulo reduction of the turn delta
    logic [32:0] mod_sub;
    assign mod_sub = 33'(dso_pkg::FULL_TURN) << k_reg;

    // heading update
    logic [HW:0] hsum;
    logic [HW-1:0] hnew;
    always_comb begin
        if (dneg_reg) begin
            hsum = {1'b0, head_reg} - (HW+1)'(rem_reg);
            hnew = hsum[HW] ? HW'(hsum + (HW+1)'(dso_pkg::FULL_TURN)) : HW'(hsum);
        end else begin
            hsum = {1'b0, head_reg} + (HW+1)'(rem_reg);
            hnew = (hsum >= (HW+1)'(dso_pkg::FULL_TURN)) ?
                   HW'(hsum - (HW+1)'(dso_pkg::FULL_TURN)) : HW'(hsum);
        end
    end

    // configuration registers and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rscale_reg <= dso_pkg::RIGHT_SCALE_RESET;
            lscale_reg <= dso_pkg::LEFT_SCALE_RESET;
            xpos_reg   <= '0;
            ypos_reg   <= '0;
            head_reg   <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    dso_pkg::REG_RIGHT_SCALE: rscale_reg <= cfg_wdata;
                    dso_pkg::REG_LEFT_SCALE:  lscale_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.mul_y) begin
                xpos_reg <= psat;
            end
            if (cmd.add_y) begin
                ypos_reg <= psat;
            end
            if (cmd.turn_add) begin
                head_reg <= hnew;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            left_reg <= s_data.lstep_cnt;
            mag_reg  <= STEPW'(diff_abs);
            dneg_reg <= diff[STEPW];
            cx_reg   <= dso_pkg::CORDIC_GAIN;
            cy_reg   <= '0;
            cz_reg   <= 34'(zred) <<< 8;
            flip_reg <= zflip;
            iter_reg <= '0;
        end
        if (cmd.cordic_step) begin
            if (!cz_reg[33]) begin
                cx_reg <= cx_reg - ysh;
                cy_reg <= cy_reg + xsh;
                cz_reg <= cz_reg - atan_v;
            end else begin
                cx_reg <= cx_reg + ysh;
                cy_reg <= cy_reg - xsh;
                cz_reg <= cz_reg + atan_v;
            end
            iter_reg <= iter_reg + IW'(1);
        end
        if (cmd.mul_x || cmd.mul_y || cmd.turn_mul) begin
            prod_reg <= mul_p;
        end
        if (cmd.turn_rnd) begin
            rem_reg <= 32'((prod_reg + MW'(128)) >>> 8);
            k_reg   <= 3'(dso_pkg::MOD_STEPS - 1);
        end
        if (cmd.mod_step) begin
            if ({1'b0, rem_reg} >= mod_sub) begin
                rem_reg <= 32'({1'b0, rem_reg} - mod_sub);
            end
            k_reg <= k_reg - 3'd1;
        end
        if (cmd.out_load) begin
            out_reg.pos_x   <= xpos_reg;
            out_reg.pos_y   <= ypos_reg;
            out_reg.heading <= head_reg;
        end
    end

endmodule

>>> hw/rtl/differential_step_odometry_unit.sv
// Dead-reckoning odometry for a two-wheel stepper robot. Each input beat reports one finished
// movement (none, straight or turn) with the signed left and right step counts; one result beat
// returns x and y (signed Q31.16 steps, saturating) and the heading (Q9.16 degrees in [0, 360)).
// Items are handled one at a time. A straight move runs the iterative CORDIC, one rotation per
// cycle, followed by one shared multiplier used for x then y. A turn runs one multiply, rounds,
// then runs an 8-step shift-subtract reduction of the heading change modulo 360 degrees. Other
// kinds go straight to the result. A result waiting in the output register holds the next
// item only in its final cycle. The two turn scales are written through cfg_we / cfg_index /
// cfg_wdata; the user must write them only while idle, which the block does not enforce.
module differential_step_odometry_unit #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  dso_pkg::in_beat_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output dso_pkg::out_beat_t              m_data,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [dso_pkg::SCALE_WIDTH-1:0] cfg_wdata
);

    dso_pkg::dp_cmd_t  dp_cmd;
    dso_pkg::dp_stat_t dp_stat;

    // sequencing
    dso_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    // arithmetic and state
    dso_dp #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (dp_cmd),
        .stat      (dp_stat)
    );

`ifndef SYNTH
    // the heading in a result is always wrapped
    a_heading_wrapped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.heading < dso_pkg::FULL_TURN))
        else $error("heading out of range");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted while busy");
`endif

endmodule
